// ===== design/rpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared constants, types and helpers for the planar RGB run-length decoder.
// ----------------------------------------------------------------------------
package rpd_pkg;

   localparam int MaxWidth   = 4096;
   localparam int AddrBits   = $clog2(MaxWidth);
   localparam int ColBits    = $clog2(MaxWidth + 1);
   localparam int ByteBits   = 8;
   localparam int PixelBits  = 24;
   localparam int CountBits  = 2;
   localparam int CsrBits    = 13;
   localparam int LeftBits   = 8;

   localparam logic [ColBits-1:0] WidthReset = ColBits'(MaxWidth);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_REPEAT,
      PH_LITERAL
   } phase_type;

   typedef enum logic [1:0] {
      PLANE_RED,
      PLANE_GREEN,
      PLANE_BLUE
   } plane_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_FILL,
      ST_LIT,
      ST_PIX,
      ST_PIX_RD
   } state_type;

   typedef struct packed {
      logic                red_we;
      logic                green_we;
      logic [AddrBits-1:0] addr;
      logic [ByteBits-1:0] data;
   } ram_ctrl_type;

   typedef struct packed {
      logic [PixelBits-1:0] first_pixel;
      logic [PixelBits-1:0] second_pixel;
      logic [CountBits-1:0] pixel_count;
      logic                 end_of_line;
      logic                 last_of_run;
      logic                 overrun_error;
   } rsp_type;

   // width 0 acts as 1, anything above the store depth as the depth
   function automatic logic [ColBits-1:0] clamp_width(input logic [CsrBits-1:0] d);
      logic [ColBits-1:0] r;
      if (d == '0) begin
         r = ColBits'(1);
      end else if (32'(d) > 32'(MaxWidth)) begin
         r = ColBits'(MaxWidth);
      end else begin
         r = ColBits'(d);
      end
      return r;
   endfunction

   function automatic plane_type next_plane(input plane_type p);
      plane_type r;
      unique case (p)
         PLANE_RED:   r = PLANE_GREEN;
         PLANE_GREEN: r = PLANE_BLUE;
         default:     r = PLANE_RED;
      endcase
      return r;
   endfunction

endpackage

// ===== design/rpd_chan_if.sv =====
// ----------------------------------------------------------------------------
// rpd_chan_if
// Valid/ready channel interfaces: code bytes in, pixel results out, width CSR.
// ----------------------------------------------------------------------------
interface rpd_req_if import rpd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ByteBits-1:0] code_byte;

   modport source (output valid, output code_byte, input ready);
   modport sink (input valid, input code_byte, output ready);
endinterface

interface rpd_rsp_if import rpd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PixelBits-1:0] first_pixel;
   logic [PixelBits-1:0] second_pixel;
   logic [CountBits-1:0] pixel_count;
   logic                 end_of_line;
   logic                 last_of_run;
   logic                 overrun_error;

   modport source (output valid, output first_pixel, output second_pixel,
                   output pixel_count, output end_of_line, output last_of_run,
                   output overrun_error, input ready);
   modport sink (input valid, input first_pixel, input second_pixel,
                 input pixel_count, input end_of_line, input last_of_run,
                 input overrun_error, output ready);
endinterface

interface rpd_csr_if import rpd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CsrBits-1:0] line_width;

   modport source (output valid, output line_width, input ready);
   modport sink (input valid, input line_width, output ready);
endinterface

// ===== design/rgb_plane_rle_decoder_core.sv =====
// ----------------------------------------------------------------------------
// rgb_plane_rle_decoder_core
// Planar RGB PackBits-style decoder with red and green line stores.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan : one compressed byte per request (valid/ready).
//   rsp_chan : decoded results, up to two packed RGB pixels each, with
//              end-of-line, last-of-run and overrun flags.
//   csr_chan : line_width write, taken only while the core is idle; a write
//              restarts decoding at the red plane, column 0.
// Timing:
//   Headers and red/green literals are taken directly in the idle state.
//   Red/green repeat runs write the line store one byte per cycle.
//   Blue literal: a registered store read, then the result.
//   Blue repeat: a store read, then one result per pixel pair, with a
//   further read state before each later pair.
//   An overrun header gives one flagged result.
// Reset clears the parser and sets line_width to 4096; line stores are not
// cleared. A stalled rsp_chan holds the result register; a request that needs
// it waits in its state and further requests are refused until it drains.
// ----------------------------------------------------------------------------
module rgb_plane_rle_decoder_core import rpd_pkg::*; (
   input logic       clock,
   input logic       reset,
   rpd_req_if.sink   req_chan,
   rpd_rsp_if.source rsp_chan,
   rpd_csr_if.sink   csr_chan
);

   ram_ctrl_type        ram;
   logic [AddrBits-1:0] addr_next;
   logic [ByteBits-1:0] red_a, red_b;
   logic [ByteBits-1:0] green_a, green_b;

   assign addr_next = ram.addr + AddrBits'(1);

   rpd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .ram      (ram),
      .red_a    (red_a),
      .red_b    (red_b),
      .green_a  (green_a),
      .green_b  (green_b)
   );

   rpd_line_ram u_red_ram (
      .clock   (clock),
      .wr_en   (ram.red_we),
      .addr_a  (ram.addr),
      .addr_b  (addr_next),
      .wr_data (ram.data),
      .rd_a    (red_a),
      .rd_b    (red_b)
   );

   rpd_line_ram u_green_ram (
      .clock   (clock),
      .wr_en   (ram.green_we),
      .addr_a  (ram.addr),
      .addr_b  (addr_next),
      .wr_data (ram.data),
      .rd_a    (green_a),
      .rd_b    (green_b)
   );

endmodule

// ===== design/rpd_line_ram.sv =====
// ----------------------------------------------------------------------------
// rpd_line_ram
// One plane line store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rpd_line_ram import rpd_pkg::*; (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] addr_a,
   input  logic [AddrBits-1:0] addr_b,
   input  logic [ByteBits-1:0] wr_data,
   output logic [ByteBits-1:0] rd_a,
   output logic [ByteBits-1:0] rd_b
);

   logic [ByteBits-1:0] mem_ff [MaxWidth];
   logic [ByteBits-1:0] rd_a_ff;
   logic [ByteBits-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr_a] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[addr_a];
      rd_b_ff <= mem_ff[addr_b];
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

// ===== design/rpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpd_ctrl
// Packet parser, column/plane sequencer, line store control and result register.
// ----------------------------------------------------------------------------
module rpd_ctrl import rpd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   rpd_req_if.sink             req_chan,
   rpd_rsp_if.source           rsp_chan,
   rpd_csr_if.sink             csr_chan,
   output ram_ctrl_type        ram,
   input  logic [ByteBits-1:0] red_a,
   input  logic [ByteBits-1:0] red_b,
   input  logic [ByteBits-1:0] green_a,
   input  logic [ByteBits-1:0] green_b
);

   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   plane_type           plane_ff, plane_in;
   logic [AddrBits-1:0] column_ff, column_in;
   logic [LeftBits-1:0] left_ff, left_in;
   logic [ByteBits-1:0] value_ff, value_in;
   logic [ColBits-1:0]  width_ff, width_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                req_ready_w;
   logic                csr_ready_w;
   logic                req_acc;
   logic                out_free;
   logic                two_step;
   logic [ColBits-1:0]  col_sum;
   logic                col_wrap;
   logic [AddrBits-1:0] col_adv;
   plane_type           plane_adv;
   logic [LeftBits-1:0] step;
   logic [LeftBits-1:0] left_dec;
   logic                left_last;
   logic [LeftBits-1:0] hdr_cnt;
   logic [ColBits-1:0]  hdr_rem;
   logic                red_plane;
   logic                green_plane;

   assign out_free    = !out_valid_ff || rsp_chan.ready;
   assign csr_ready_w = (state_ff == ST_IDLE);
   assign req_ready_w = (state_ff == ST_IDLE) && !csr_chan.valid;
   assign req_acc     = req_ready_w && req_chan.valid;

   assign two_step  = (state_ff == ST_PIX) && (left_ff >= LeftBits'(2));
   assign step      = two_step ? LeftBits'(2) : LeftBits'(1);
   assign col_sum   = ColBits'(column_ff) + ColBits'(step);
   assign col_wrap  = (col_sum >= width_ff);
   assign col_adv   = col_wrap ? '0 : col_sum[AddrBits-1:0];
   assign plane_adv = col_wrap ? next_plane(plane_ff) : plane_ff;
   assign left_dec  = left_ff - step;
   assign left_last = (left_ff <= step);

   assign hdr_cnt = req_chan.code_byte[ByteBits-1] ? (~req_chan.code_byte + 8'd1)
                                                   : req_chan.code_byte;
   assign hdr_rem = width_ff - ColBits'(column_ff);

   assign red_plane   = (plane_ff == PLANE_RED);
   assign green_plane = (plane_ff == PLANE_GREEN);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      plane_in     = plane_ff;
      column_in    = column_ff;
      left_in      = left_ff;
      value_in     = value_ff;
      width_in     = width_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      ram          = '0;
      ram.addr     = column_ff;
      ram.data     = value_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_chan.valid) begin
               width_in  = clamp_width(csr_chan.line_width);
               phase_in  = PH_HEADER;
               left_in   = '0;
               column_in = '0;
               plane_in  = PLANE_RED;
            end else if (req_acc) begin
               unique case (phase_ff)
                  PH_HEADER: begin
                     if (req_chan.code_byte != '0) begin
                        phase_in = req_chan.code_byte[ByteBits-1] ? PH_REPEAT : PH_LITERAL;
                        if (ColBits'(hdr_cnt) > hdr_rem) begin
                           left_in  = hdr_rem[LeftBits-1:0];
                           state_in = ST_ERR;
                        end else begin
                           left_in = hdr_cnt;
                        end
                     end
                  end
                  PH_REPEAT: begin
                     value_in = req_chan.code_byte;
                     state_in = (plane_ff == PLANE_BLUE) ? ST_PIX : ST_FILL;
                  end
                  PH_LITERAL: begin
                     value_in = req_chan.code_byte;
                     if (plane_ff == PLANE_BLUE) begin
                        state_in = ST_LIT;
                     end else begin
                        ram.red_we   = red_plane;
                        ram.green_we = green_plane;
                        ram.data     = req_chan.code_byte;
                        column_in    = col_adv;
                        plane_in     = plane_adv;
                        left_in      = left_dec;
                        if (left_last) begin
                           phase_in = PH_HEADER;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ERR: begin
            if (out_free) begin
               out_valid_in         = 1'b1;
               rsp_in               = '0;
               rsp_in.last_of_run   = 1'b1;
               rsp_in.overrun_error = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         ST_FILL: begin
            ram.red_we   = red_plane;
            ram.green_we = green_plane;
            column_in    = col_adv;
            plane_in     = plane_adv;
            left_in      = left_dec;
            if (left_last) begin
               phase_in = PH_HEADER;
               state_in = ST_IDLE;
            end
         end
         ST_LIT: begin
            if (out_free) begin
               out_valid_in         = 1'b1;
               rsp_in.first_pixel   = {red_a, green_a, value_ff};
               rsp_in.second_pixel  = '0;
               rsp_in.pixel_count   = CountBits'(1);
               rsp_in.end_of_line   = (col_sum == width_ff);
               rsp_in.last_of_run   = 1'b1;
               rsp_in.overrun_error = 1'b0;
               column_in            = col_adv;
               plane_in             = plane_adv;
               left_in              = left_dec;
               if (left_last) begin
                  phase_in = PH_HEADER;
               end
               state_in = ST_IDLE;
            end
         end
         ST_PIX: begin
            if (out_free) begin
               out_valid_in         = 1'b1;
               rsp_in.first_pixel   = {red_a, green_a, value_ff};
               rsp_in.second_pixel  = two_step ? {red_b, green_b, value_ff} : '0;
               rsp_in.pixel_count   = two_step ? CountBits'(2) : CountBits'(1);
               rsp_in.end_of_line   = (col_sum == width_ff);
               rsp_in.last_of_run   = left_last;
               rsp_in.overrun_error = 1'b0;
               column_in            = col_adv;
               plane_in             = plane_adv;
               left_in              = left_dec;
               if (left_last) begin
                  phase_in = PH_HEADER;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_PIX_RD;
               end
            end
         end
         ST_PIX_RD: begin
            // store read of the new column pair is in flight
            state_in = ST_PIX;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_HEADER;
         plane_ff     <= PLANE_RED;
         column_ff    <= '0;
         left_ff      <= '0;
         width_ff     <= WidthReset;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         plane_ff     <= plane_in;
         column_ff    <= column_in;
         left_ff      <= left_in;
         width_ff     <= width_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign req_chan.ready = req_ready_w;
   assign csr_chan.ready = csr_ready_w;

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.first_pixel   = rsp_ff.first_pixel;
   assign rsp_chan.second_pixel  = rsp_ff.second_pixel;
   assign rsp_chan.pixel_count   = rsp_ff.pixel_count;
   assign rsp_chan.end_of_line   = rsp_ff.end_of_line;
   assign rsp_chan.last_of_run   = rsp_ff.last_of_run;
   assign rsp_chan.overrun_error = rsp_ff.overrun_error;

endmodule
